/* rtl/core/lbcd_pkg.sv */
// Shared constants, types and helpers of the LRU block cache directory.
package lbcd_pkg;

   localparam int NUM_SLOTS    = 8;
   localparam int BLOCK_BITS   = 32;
   localparam int SLOT_W       = $clog2(NUM_SLOTS);
   localparam int REQ_BLOCK_W  = 32;
   localparam int SLOT_FIELD_W = 3;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   // Access kinds carried on the command field.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Recency update request sent to the age tracker.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } lbcd_promote_type;

   // Tag compared against the stored tags: the low BLOCK_BITS bits of the block number.
   function automatic logic [BLOCK_BITS-1:0] block_to_tag(input logic [REQ_BLOCK_W-1:0] blk);
      logic [REQ_BLOCK_W+BLOCK_BITS-1:0] wide;
      wide = {{BLOCK_BITS{1'b0}}, blk};
      return wide[BLOCK_BITS-1:0];
   endfunction

   // Slot number as reported on the result channel, masked to the field width.
   function automatic logic [SLOT_FIELD_W-1:0] slot_to_field(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
      wide = {{SLOT_FIELD_W{1'b0}}, s};
      return wide[SLOT_FIELD_W-1:0];
   endfunction

endpackage

/* rtl/core/lru_block_cache_directory.sv */
// Top level of the LRU block cache directory: tag scan, allocation and result register.
// A request's tag is checked against the tag RAM one entry per cycle, from slot 0
// upward, until a match or the last slot; a miss scans every slot. One request is in
// work at a time: a new request is taken only after the last one has committed its
// result. The next request is taken while an earlier result still waits in the output
// register. Reset invalidates every slot and makes slot 0 the least recently used.
module lru_block_cache_directory
   import lbcd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [REQ_BLOCK_W-1:0]  req_block,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [SLOT_FIELD_W-1:0] rsp_slot,
   output logic                    rsp_fetch,
   output logic                    rsp_touched
);

   // Sequencer: wait for a request, scan the tags, then commit and hand over the result.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } lbcd_state_type;

   lbcd_state_type state_ff, state_in;

   logic                  cmd_ff, cmd_in;
   logic [BLOCK_BITS-1:0] tag_ff, tag_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     hit_slot_ff, hit_slot_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                    rsp_fetch_ff, rsp_fetch_in;
   logic                    rsp_touched_ff, rsp_touched_in;

   logic                  req_xfer;
   logic                  out_free;
   logic                  commit;
   logic                  match;
   logic                  read_miss;
   logic [SLOT_W-1:0]     victim_slot;
   logic [SLOT_W-1:0]     final_slot;
   logic [SLOT_W-1:0]     ram_rd_addr;
   logic [BLOCK_BITS-1:0] ram_rd_data;
   lbcd_promote_type      promote;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // The result register can take a new result when empty or when it is being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_DONE) && out_free;

   // Read data arriving in the scan belongs to entry idx_ff; the next entry is requested
   // alongside. On the last entry the extra read address wraps and its data goes unused.
   assign ram_rd_addr = (state_ff == ST_SCAN) ? idx_ff + 1'b1 : '0;
   assign match       = valid_ff[idx_ff] && (ram_rd_data == tag_ff);

   assign read_miss  = !found_ff && (cmd_ff == CMD_READ);
   assign final_slot = found_ff ? hit_slot_ff : (read_miss ? victim_slot : '0);

   assign promote.valid = commit && (found_ff || read_miss);
   assign promote.slot  = final_slot;

   lbcd_ram #(
      .WIDTH (BLOCK_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (commit && read_miss),
      .wr_addr (victim_slot),
      .wr_data (tag_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lbcd_age u_age (
      .clock       (clock),
      .reset       (reset),
      .promote     (promote),
      .oldest_slot (victim_slot)
   );

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      tag_in      = tag_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      hit_slot_in = hit_slot_ff;
      valid_in    = valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_cmd;
               tag_in   = block_to_tag(req_block);
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The lowest-numbered matching slot wins since the scan runs upward.
            priority if (match) begin
               found_in    = 1'b1;
               hit_slot_in = idx_ff;
               state_in    = ST_DONE;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (commit) begin
               if (read_miss) begin
                  valid_in[victim_slot] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fetch_in   = rsp_fetch_ff;
      rsp_touched_in = rsp_touched_ff;
      if (commit) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = found_ff;
         rsp_slot_in    = slot_to_field(final_slot);
         rsp_fetch_in   = read_miss;
         rsp_touched_in = found_ff || read_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tag_ff         <= tag_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      hit_slot_ff    <= hit_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fetch_ff   <= rsp_fetch_in;
      rsp_touched_ff <= rsp_touched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_fetch   = rsp_fetch_ff;
   assign rsp_touched = rsp_touched_ff;

endmodule

/* rtl/core/lbcd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module lbcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lbcd_age.sv */
// Recency ranks of all slots, promotion to most recently used and victim selection.
module lbcd_age
   import lbcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lbcd_promote_type  promote,
   output logic [SLOT_W-1:0] oldest_slot
);

   logic [SLOT_W-1:0] age_ff [NUM_SLOTS];
   logic [SLOT_W-1:0] age_in [NUM_SLOTS];
   logic [SLOT_W-1:0] promoted_age;

   assign promoted_age = age_ff[promote.slot];

   // The promoted slot takes the top rank; every slot above its old rank moves down one.
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         age_in[i] = age_ff[i];
         if (promote.valid) begin
            if (SLOT_W'(i) == promote.slot) begin
               age_in[i] = LAST_SLOT;
            end else if (age_ff[i] > promoted_age) begin
               age_in[i] = age_ff[i] - 1'b1;
            end
         end
      end
   end

   // Victim is the lowest-numbered slot holding rank zero.
   always_comb begin
      logic seen;
      seen        = 1'b0;
      oldest_slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!seen && age_ff[i] == '0) begin
            seen        = 1'b1;
            oldest_slot = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            age_ff[i] <= SLOT_W'(i);
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

endmodule
